// ----- rtl/fpm_pkg.sv -----
// Package: shared types and constants for the binary32 multiplier.
`timescale 1ns / 1ps
package fpm_pkg;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_ALL   = 8'hFF;
    localparam logic [9:0]  EXP_BIAS  = 10'd127;

    typedef enum logic [1:0] {
        CLS_NORMAL = 2'd0,
        CLS_NAN    = 2'd1,
        CLS_INF    = 2'd2,
        CLS_ZERO   = 2'd3
    } fp_class_t;

    // stage 1 -> stage 2 payload
    typedef struct packed {
        logic        sign;
        fp_class_t   cls;
        logic [9:0]  exp;
        logic [23:0] sig_a;
        logic [23:0] sig_b;
    } unpack_t;

    // stage 2 -> stage 3 payload
    typedef struct packed {
        logic        sign;
        fp_class_t   cls;
        logic [9:0]  exp;
        logic [47:0] prod;
    } mult_t;
endpackage

// ----- rtl/fpm_if.sv -----
// Interfaces: valid/ready channels for operand pairs and products.
`timescale 1ns / 1ps
interface fpm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface fpm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] product;
    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface

// ----- rtl/fpm_unpack.sv -----
// Stage 1 logic: classify operands and form sign, exponent sum, significands.
`timescale 1ns / 1ps
module fpm_unpack (
    input  logic            [31:0] operand_a,
    input  logic            [31:0] operand_b,
    output fpm_pkg::unpack_t       result
);
    import fpm_pkg::*;

    logic [7:0] ea, eb;
    logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    always_comb
    begin
        ea     = operand_a[30:23];
        eb     = operand_b[30:23];
        a_nan  = (ea == EXP_ALL) && (operand_a[22:0] != 23'd0);
        b_nan  = (eb == EXP_ALL) && (operand_b[22:0] != 23'd0);
        a_inf  = (ea == EXP_ALL) && (operand_a[22:0] == 23'd0);
        b_inf  = (eb == EXP_ALL) && (operand_b[22:0] == 23'd0);
        a_zero = (ea == 8'd0);
        b_zero = (eb == 8'd0);
        result.sign  = operand_a[31] ^ operand_b[31];
        result.exp   = {2'b00, ea} + {2'b00, eb} - EXP_BIAS;
        result.sig_a = {1'b1, operand_a[22:0]};
        result.sig_b = {1'b1, operand_b[22:0]};
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
            result.cls = CLS_NAN;
        else if (a_inf || b_inf)
            result.cls = CLS_INF;
        else if (a_zero || b_zero)
            result.cls = CLS_ZERO;
        else
            result.cls = CLS_NORMAL;
    end
endmodule

// ----- rtl/fpm_round.sv -----
// Stage 3 logic: normalize, round to nearest even, and pack the result.
`timescale 1ns / 1ps
module fpm_round (
    input  fpm_pkg::mult_t        op,
    output logic           [31:0] product
);
    import fpm_pkg::*;

    logic [9:0]  exp;
    logic [24:0] mant;
    logic        guard, sticky;

    always_comb
    begin
        if (op.prod[47])
        begin
            exp    = op.exp + 10'd1;
            mant   = {1'b0, op.prod[47:24]};
            guard  = op.prod[23];
            sticky = |op.prod[22:0];
        end
        else
        begin
            exp    = op.exp;
            mant   = {1'b0, op.prod[46:23]};
            guard  = op.prod[22];
            sticky = |op.prod[21:0];
        end
        if (guard && (sticky || mant[0]))
            mant = mant + 25'd1;
        if (mant[24])
        begin
            mant = mant >> 1;
            exp  = exp + 10'd1;
        end
        // exp is signed in 10 bits: bit 9 set means negative
        case (op.cls)
            CLS_NAN:  product = QNAN_BITS;
            CLS_INF:  product = {op.sign, EXP_ALL, 23'd0};
            CLS_ZERO: product = {op.sign, 31'd0};
            default:
            begin
                if (exp[9] || exp == 10'd0)
                    product = {op.sign, 31'd0};
                else if (exp >= 10'd255)
                    product = {op.sign, EXP_ALL, 23'd0};
                else
                    product = {op.sign, exp[7:0], mant[22:0]};
            end
        endcase
    end
endmodule

// ----- rtl/fp32_multiplier.sv -----
// Top level: three-stage pipelined IEEE 754 binary32 multiplier.
//
//  Channel   Dir  Payload                  Transaction when
//  in_ch     in   operand_a, operand_b     in_ch.valid && in_ch.ready
//  out_ch    out  product                  out_ch.valid && out_ch.ready
//
// Pipeline stages: unpack, 24x24 significand multiply, round/pack.
// One transaction enters per cycle while out_ch is not stalled. Each stage
// advances when its successor is empty or advancing, so a stall on out_ch
// backs up the pipe without loss or repeat. Reset clears the stage valid
// bits only.
`timescale 1ns / 1ps
module fp32_multiplier (
    input  logic clk,
    input  logic rst_n,
    fpm_in_if.sink    in_ch,
    fpm_out_if.source out_ch
);
    import fpm_pkg::*;

    unpack_t     s1_next, s1_reg;
    mult_t       s2_reg;
    logic [31:0] s3_next, s3_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;

    // stall chain: a stage takes new data when its output slot frees up
    assign adv3 = !v3_reg || out_ch.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ch.ready = adv1;

    fpm_unpack u_unpack (
        .operand_a (in_ch.operand_a),
        .operand_b (in_ch.operand_b),
        .result    (s1_next)
    );

    fpm_round u_round (
        .op      (s2_reg),
        .product (s3_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_ch.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (adv1 && in_ch.valid)
            s1_reg <= s1_next;
        if (adv2 && v1_reg)
        begin
            s2_reg.sign <= s1_reg.sign;
            s2_reg.cls  <= s1_reg.cls;
            s2_reg.exp  <= s1_reg.exp;
            s2_reg.prod <= s1_reg.sig_a * s1_reg.sig_b;
        end
        if (adv3 && v2_reg)
            s3_reg <= s3_next;
    end

    assign out_ch.valid   = v3_reg;
    assign out_ch.product = s3_reg;

    // a stalled output must not be overwritten
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.product))
        else $error("output changed during stall");

    // an accepted transaction reaches stage 2 next cycle when unstalled
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && adv2 |=> v2_reg)
        else $error("stage 1 transaction dropped");

    // the input is stalled only when every stage holds a transaction
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> v1_reg && v2_reg && v3_reg)
        else $error("input stalled with empty stage");
endmodule
